[src/im2c_pkg.sv]
// Shared types, constants and helpers of the im2col window address generator.
// No dependencies; imported by every module of the block.
package im2c_pkg;

    // Dimension limits
    localparam int MAX_DIM      = 1024;
    localparam int MAX_CHANNELS = 1024;
    localparam int GROUP_LANES  = 4;

    // Field and internal widths
    localparam int DIM_W      = 11;          // width/height/channel register fields
    localparam int CH_W       = 10;          // channel counter
    localparam int K_W        = 4;           // kernel, stride, dilation, pad fields
    localparam int LANE_W     = 2;
    localparam int PIX_W      = 21;          // pixel index and group start
    localparam int ADDR_W     = 30;          // source offset
    localparam int COORD_W    = 15;          // unpadded input coordinate
    localparam int DIV_STEPS  = PIX_W;       // one quotient bit per divider step
    localparam int DIV_CNT_W  = 5;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(GROUP_LANES - 1);

    // Register map, word index taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_CHANNELS = 3'd0,
        REG_IN_SIZE  = 3'd1,
        REG_OUT_SIZE = 3'd2,
        REG_KERNEL   = 3'd3,
        REG_STRIDE   = 3'd4,
        REG_DILATION = 3'd5,
        REG_PAD      = 3'd6
    } reg_idx_t;

    // Configuration as held in the register file
    typedef struct packed {
        logic [DIM_W-1:0]   channels;
        logic [2*DIM_W-1:0] in_size;
        logic [2*DIM_W-1:0] out_size;
        logic [2*K_W-1:0]   kernel_dims;
        logic [2*K_W-1:0]   stride_dims;
        logic [2*K_W-1:0]   dilation_dims;
        logic [2*K_W-1:0]   pad_before;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // latch the input transfer
        logic prep;       // register the size products
        logic eval;       // check and advance counters, start the divider
        logic div_step;   // one divider iteration
        logic coord;      // input coordinates and bounds
        logic offs;       // channel and row offsets
        logic load_out;   // final sum into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;      // job has no elements
        logic div_last;   // current divider step is the final one
        logic out_free;   // output register can take a result this cycle
    } status_t;

    // Clamp a dimension field to MAX_DIM
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

endpackage

[src/im2c_regs.sv]
// Configuration register file with APB-style access.
// Depends on im2c_pkg for the register map and the cfg_t bundle.
module im2c_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [im2c_pkg::PADDR_W-1:0]  paddr,
    input  logic [im2c_pkg::PDATA_W-1:0]  pwdata,
    output logic [im2c_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output im2c_pkg::cfg_t                cfg
);
    import im2c_pkg::*;

    logic [DIM_W-1:0]   channels_reg;
    logic [2*DIM_W-1:0] in_size_reg;
    logic [2*DIM_W-1:0] out_size_reg;
    logic [2*K_W-1:0]   kernel_reg;
    logic [2*K_W-1:0]   stride_reg;
    logic [2*K_W-1:0]   dilation_reg;
    logic [2*K_W-1:0]   pad_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= DIM_W'(1);
            in_size_reg  <= 22'd16392;
            out_size_reg <= 22'd16392;
            kernel_reg   <= 8'd51;
            stride_reg   <= 8'd17;
            dilation_reg <= 8'd17;
            pad_reg      <= 8'd0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CHANNELS: channels_reg <= pwdata[DIM_W-1:0];
                REG_IN_SIZE:  in_size_reg  <= pwdata[2*DIM_W-1:0];
                REG_OUT_SIZE: out_size_reg <= pwdata[2*DIM_W-1:0];
                REG_KERNEL:   kernel_reg   <= pwdata[2*K_W-1:0];
                REG_STRIDE:   stride_reg   <= pwdata[2*K_W-1:0];
                REG_DILATION: dilation_reg <= pwdata[2*K_W-1:0];
                REG_PAD:      pad_reg      <= pwdata[2*K_W-1:0];
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_CHANNELS: prdata = PDATA_W'(channels_reg);
            REG_IN_SIZE:  prdata = PDATA_W'(in_size_reg);
            REG_OUT_SIZE: prdata = PDATA_W'(out_size_reg);
            REG_KERNEL:   prdata = PDATA_W'(kernel_reg);
            REG_STRIDE:   prdata = PDATA_W'(stride_reg);
            REG_DILATION: prdata = PDATA_W'(dilation_reg);
            REG_PAD:      prdata = PDATA_W'(pad_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.channels      = channels_reg;
    assign cfg.in_size       = in_size_reg;
    assign cfg.out_size      = out_size_reg;
    assign cfg.kernel_dims   = kernel_reg;
    assign cfg.stride_dims   = stride_reg;
    assign cfg.dilation_dims = dilation_reg;
    assign cfg.pad_before    = pad_reg;

endmodule

[src/im2c_ctrl.sv]
// Sequencing state machine: walks one transfer through prep, divide and address stages.
// Depends on im2c_pkg for the command and status bundles.
module im2c_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  im2c_pkg::status_t  status,
    output im2c_pkg::cmd_t     cmd
);
    import im2c_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_COORD = 7'b0010000,
        S_OFFS  = 7'b0100000,
        S_SUM   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_PREP;
            S_PREP:  state_next = S_EVAL;
            S_EVAL:  state_next = status.empty ? S_IDLE : S_DIV;
            S_DIV:   if (status.div_last) state_next = S_COORD;
            S_COORD: state_next = S_OFFS;
            S_OFFS:  state_next = S_SUM;
            S_SUM:   if (status.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Commands
    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.accept   = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.prep     = (state_reg == S_PREP);
    assign cmd.eval     = (state_reg == S_EVAL) && !status.empty;
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.coord    = (state_reg == S_COORD);
    assign cmd.offs     = (state_reg == S_OFFS);
    assign cmd.load_out = (state_reg == S_SUM) && status.out_free;

`ifndef NO_ASSERTIONS
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_last) |=> state_reg == S_COORD)
        else $error("divider exit missed");
    a_empty_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && status.empty) |=> state_reg == S_IDLE)
        else $error("empty job did not return to idle");
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && !status.out_free) |=> state_reg == S_SUM)
        else $error("result dropped while output busy");
`endif

endmodule

[src/im2c_dp.sv]
// Datapath: walk counters, pixel divider, coordinate and offset arithmetic, output register.
// Depends on im2c_pkg; driven by im2c_ctrl commands.
module im2c_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  im2c_pkg::cfg_t                cfg,
    input  im2c_pkg::cmd_t                cmd,
    output im2c_pkg::status_t             status,
    input  logic                          restart,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [im2c_pkg::ADDR_W-1:0]   source_address,
    output logic                          zero_fill,
    output logic [im2c_pkg::LANE_W-1:0]   lane,
    output logic                          last
);
    import im2c_pkg::*;

    // Decoded configuration
    logic [DIM_W-1:0] nch, iw, ih, ow, oh;
    logic [K_W-1:0]   kw, kh, sw, sh, dw, dh, pw, ph;

    assign nch = (cfg.channels > DIM_W'(MAX_CHANNELS)) ? DIM_W'(MAX_CHANNELS) : cfg.channels;
    assign iw  = sat_dim(cfg.in_size[DIM_W-1:0]);
    assign ih  = sat_dim(cfg.in_size[2*DIM_W-1:DIM_W]);
    assign ow  = sat_dim(cfg.out_size[DIM_W-1:0]);
    assign oh  = sat_dim(cfg.out_size[2*DIM_W-1:DIM_W]);
    assign kw  = cfg.kernel_dims[K_W-1:0];
    assign kh  = cfg.kernel_dims[2*K_W-1:K_W];
    assign sw  = cfg.stride_dims[K_W-1:0];
    assign sh  = cfg.stride_dims[2*K_W-1:K_W];
    assign dw  = cfg.dilation_dims[K_W-1:0];
    assign dh  = cfg.dilation_dims[2*K_W-1:K_W];
    assign pw  = cfg.pad_before[K_W-1:0];
    assign ph  = cfg.pad_before[2*K_W-1:K_W];

    assign status.empty = (nch == '0) || (ow == '0) || (oh == '0) || (kw == '0) || (kh == '0);

    // Walk counters
    logic [PIX_W-1:0]  gfp_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [K_W-1:0]    krow_reg, kcol_reg;
    logic [LANE_W-1:0] lane_reg;

    // Latched input and size products
    logic              restart_reg;
    logic [PIX_W-1:0]  npix_reg;
    logic [PIX_W-1:0]  area_reg;

    // Per-element working copies
    logic [CH_W-1:0]   w_ch_reg;
    logic [K_W-1:0]    w_krow_reg, w_kcol_reg;
    logic [LANE_W-1:0] w_lane_reg;
    logic              w_last_reg, w_valid_reg;

    // Divider
    logic [PIX_W-1:0]     quo_reg;
    logic [DIM_W-2:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Coordinate and offset stages
    logic [DIM_W-1:0]   ix_reg, iy_reg;
    logic               inside_reg;
    logic [ADDR_W-1:0]  chan_off_reg;
    logic [2*DIM_W-1:0] row_off_reg;

    // Output register
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_zero_reg, out_last_reg, out_valid_reg;
    logic [LANE_W-1:0] out_lane_reg;

    // Counter check, clear and advance
    logic              oob, last_eval;
    logic [PIX_W-1:0]  gfp_eff, gfp_next;
    logic [CH_W-1:0]   ch_eff, ch_next;
    logic [K_W-1:0]    krow_eff, krow_next, kcol_eff, kcol_next;
    logic [LANE_W-1:0] lane_eff, lane_next;
    logic [PIX_W:0]    pix_eval;

    assign oob = restart_reg || (gfp_reg >= npix_reg) || ({1'b0, ch_reg} >= nch)
                 || (krow_reg >= kh) || (kcol_reg >= kw);
    assign gfp_eff  = oob ? '0 : gfp_reg;
    assign ch_eff   = oob ? '0 : ch_reg;
    assign krow_eff = oob ? '0 : krow_reg;
    assign kcol_eff = oob ? '0 : kcol_reg;
    assign lane_eff = oob ? '0 : lane_reg;

    assign last_eval = (({1'b0, gfp_eff} + (PIX_W+1)'(GROUP_LANES)) >= {1'b0, npix_reg})
                       && ({1'b0, ch_eff} == nch - DIM_W'(1))
                       && (krow_eff == kh - K_W'(1))
                       && (kcol_eff == kw - K_W'(1))
                       && (lane_eff == LANE_LAST);
    assign pix_eval = {1'b0, gfp_eff} + (PIX_W+1)'(lane_eff);

    always_comb
    begin
        gfp_next  = gfp_eff;
        ch_next   = ch_eff;
        krow_next = krow_eff;
        kcol_next = kcol_eff;
        lane_next = lane_eff;
        if (last_eval)
        begin
            gfp_next  = '0;
            ch_next   = '0;
            krow_next = '0;
            kcol_next = '0;
            lane_next = '0;
        end
        else if (lane_eff != LANE_LAST)
            lane_next = lane_eff + LANE_W'(1);
        else
        begin
            lane_next = '0;
            if ({1'b0, kcol_eff} + (K_W+1)'(1) < {1'b0, kw})
                kcol_next = kcol_eff + K_W'(1);
            else
            begin
                kcol_next = '0;
                if ({1'b0, krow_eff} + (K_W+1)'(1) < {1'b0, kh})
                    krow_next = krow_eff + K_W'(1);
                else
                begin
                    krow_next = '0;
                    if ({1'b0, ch_eff} + DIM_W'(1) < nch)
                        ch_next = ch_eff + CH_W'(1);
                    else
                    begin
                        ch_next  = '0;
                        gfp_next = gfp_eff + PIX_W'(GROUP_LANES);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gfp_reg  <= '0;
            ch_reg   <= '0;
            krow_reg <= '0;
            kcol_reg <= '0;
            lane_reg <= '0;
        end
        else if (cmd.eval)
        begin
            gfp_reg  <= gfp_next;
            ch_reg   <= ch_next;
            krow_reg <= krow_next;
            kcol_reg <= kcol_next;
            lane_reg <= lane_next;
        end
    end

    // Input latch, size products and element snapshot
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            restart_reg <= restart;
        if (cmd.prep)
        begin
            npix_reg <= PIX_W'(ow * oh);
            area_reg <= PIX_W'(iw * ih);
        end
        if (cmd.eval)
        begin
            w_ch_reg    <= ch_eff;
            w_krow_reg  <= krow_eff;
            w_kcol_reg  <= kcol_eff;
            w_lane_reg  <= lane_eff;
            w_last_reg  <= last_eval;
            w_valid_reg <= pix_eval < {1'b0, npix_reg};
        end
    end

    // Restoring divider: pixel index / output width, one quotient bit per cycle
    logic [DIM_W-1:0] div_shift, div_diff;
    logic             div_ge;

    assign div_shift = {rem_reg, quo_reg[PIX_W-1]};
    assign div_ge    = div_shift >= ow;
    assign div_diff  = div_shift - ow;
    assign status.div_last = (div_cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            quo_reg <= pix_eval[PIX_W-1:0];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PIX_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[DIM_W-2:0] : div_shift[DIM_W-2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.eval)
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1);
        else if (cmd.div_step && div_cnt_reg != '0)
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
    end

    // Input coordinates before padding, then bounds check
    logic [COORD_W-1:0] pos_x, pos_y, ix_c, iy_c;
    logic               in_x, in_y;

    assign pos_x = COORD_W'(rem_reg) * COORD_W'(sw) + COORD_W'(w_kcol_reg) * COORD_W'(dw);
    assign pos_y = COORD_W'(quo_reg[DIM_W-1:0]) * COORD_W'(sh)
                   + COORD_W'(w_krow_reg) * COORD_W'(dh);
    assign ix_c  = pos_x - COORD_W'(pw);
    assign iy_c  = pos_y - COORD_W'(ph);
    assign in_x  = (pos_x >= COORD_W'(pw)) && (ix_c < COORD_W'(iw));
    assign in_y  = (pos_y >= COORD_W'(ph)) && (iy_c < COORD_W'(ih));

    // Coordinate, offset stages and final sum
    logic [ADDR_W-1:0] addr_sum;

    assign addr_sum = chan_off_reg + ADDR_W'(row_off_reg) + ADDR_W'(ix_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.coord)
        begin
            ix_reg     <= ix_c[DIM_W-1:0];
            iy_reg     <= iy_c[DIM_W-1:0];
            inside_reg <= w_valid_reg && in_x && in_y;
        end
        if (cmd.offs)
        begin
            chan_off_reg <= ADDR_W'(w_ch_reg) * ADDR_W'(area_reg);
            row_off_reg  <= (2*DIM_W)'(iy_reg) * (2*DIM_W)'(iw);
        end
        if (cmd.load_out)
        begin
            out_addr_reg <= inside_reg ? addr_sum : '0;
            out_zero_reg <= !inside_reg;
            out_lane_reg <= w_lane_reg;
            out_last_reg <= w_last_reg;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign source_address  = out_addr_reg;
    assign zero_fill       = out_zero_reg;
    assign lane            = out_lane_reg;
    assign last            = out_last_reg;

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output overwritten before transfer");
    a_last_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_lane_reg == LANE_LAST)
        else $error("last element not on final lane");
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> div_cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1))
        else $error("divider step count out of range");
`endif

endmodule

[src/im2col_window_address_generator.sv]
// Top level of the im2col window address generator: stream ports, APB config port.
// Depends on im2c_pkg, im2c_regs, im2c_ctrl and im2c_dp.
//
// Each input transfer yields one column element (or none if the job is empty:
// zero channels, output width/height or kernel width/height). Output pixels go in
// groups of four lanes; per group the walk is channel, kernel row, kernel column,
// lane innermost, and wraps after the element flagged with tlast. A transfer with
// restart set starts the job over. An item goes through the input transfer, size
// products, counter update, the radix-2 divider that splits the pixel index into row
// and column by the output width, then the coordinate, offset and sum stages. When the
// output side is free, the result is then registered and the next input is taken in
// the following cycle; no new input is taken while an item is in flight.
// s_tready goes high again as soon as the result is registered, even while it waits
// on m_tready. An empty-job input produces nothing. Registers may be written only
// while no item is in flight.
module im2col_window_address_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] restart
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [29:0] source_address
    output logic [2:0]                    m_tuser,   // [0] zero_fill, [2:1] lane
    output logic                          m_tlast,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [im2c_pkg::PADDR_W-1:0]  paddr,
    input  logic [im2c_pkg::PDATA_W-1:0]  pwdata,
    output logic [im2c_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import im2c_pkg::*;

    cfg_t              cfg;
    cmd_t              cmd;
    status_t           status;
    logic [ADDR_W-1:0] source_address;
    logic              zero_fill;
    logic [LANE_W-1:0] lane;

    im2c_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    im2c_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    im2c_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .restart        (s_tdata[0]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .source_address (source_address),
        .zero_fill      (zero_fill),
        .lane           (lane),
        .last           (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {2'b00, source_address};
    assign m_tuser = {lane, zero_fill};

endmodule
